### hw/rtl/gbm_pkg.sv
package gbm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CP_BITS = 21;
  localparam int OUT_COUNT_BITS = 16;

  localparam logic [CP_BITS-1:0] CP_CR = 21'h0000D;
  localparam logic [CP_BITS-1:0] CP_LF = 21'h0000A;
  localparam logic [CP_BITS-1:0] CP_ZWJ = 21'h0200D;
  localparam logic [CP_BITS-1:0] RI_FIRST = 21'h1F1E6;
  localparam logic [CP_BITS-1:0] RI_LAST = 21'h1F1FF;

  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_CLOSED    = 3'd1,
    MODE_AFTER_CR  = 3'd2,
    MODE_AFTER_RI  = 3'd3,
    MODE_EXTENDING = 3'd4,
    MODE_JOINED    = 3'd5
  } cluster_mode_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_zwj;
    logic regional;
    logic attach;
  } cp_class_t;

  typedef struct packed {
    logic [CP_BITS-1:0] lo;
    logic [CP_BITS-1:0] hi;
  } span_t;

  localparam int SPAN_COUNT = 47;

  // extend marks, then the variation selectors
  localparam span_t ATTACH_SPANS [SPAN_COUNT] = '{
    '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005BD},
    '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2}, '{21'h005C4, 21'h005C5},
    '{21'h005C7, 21'h005C7}, '{21'h00610, 21'h0061A}, '{21'h0064B, 21'h0065F},
    '{21'h00670, 21'h00670}, '{21'h006D6, 21'h006DC}, '{21'h006DF, 21'h006E4},
    '{21'h006E7, 21'h006E8}, '{21'h006EA, 21'h006ED}, '{21'h00711, 21'h00711},
    '{21'h00730, 21'h0074A}, '{21'h007A6, 21'h007B0}, '{21'h00900, 21'h00902},
    '{21'h0093A, 21'h0093A}, '{21'h0093C, 21'h0093C}, '{21'h00941, 21'h00948},
    '{21'h0094D, 21'h0094D}, '{21'h00951, 21'h00957}, '{21'h00962, 21'h00963},
    '{21'h00980, 21'h00983}, '{21'h009BC, 21'h009BC}, '{21'h00A01, 21'h00A03},
    '{21'h00E31, 21'h00E31}, '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E},
    '{21'h00EB1, 21'h00EB1}, '{21'h00EB4, 21'h00EBC}, '{21'h00EC8, 21'h00ECD},
    '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF}, '{21'h0200C, 21'h0200C},
    '{21'h020D0, 21'h020FF}, '{21'h0302A, 21'h0302F}, '{21'h03099, 21'h0309A},
    '{21'h0A66F, 21'h0A672}, '{21'h0A674, 21'h0A67D}, '{21'h0A69E, 21'h0A69F},
    '{21'h0FE20, 21'h0FE2F}, '{21'h1F3FB, 21'h1F3FF}, '{21'hE0020, 21'hE007F},
    '{21'h0FE00, 21'h0FE0F}, '{21'hE0100, 21'hE01EF}
  };

  // clamp the internal count to the output field
  function automatic logic [OUT_COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    if (w > 33'h0FFFF) begin
      return '1;
    end
    return w[OUT_COUNT_BITS-1:0];
  endfunction

endpackage

### hw/rtl/gbm_in_if.sv
interface gbm_in_if import gbm_pkg::*; (input logic clk);
  logic               valid;
  logic               ready;
  logic [CP_BITS-1:0] codepoint;
  logic               is_last;

  modport source (input clk, output valid, output codepoint, output is_last, input ready);
  modport sink (input clk, input valid, input codepoint, input is_last, output ready);
endinterface

### hw/rtl/gbm_out_if.sv
interface gbm_out_if import gbm_pkg::*; (input logic clk);
  logic                      valid;
  logic                      ready;
  logic                      boundary_before;
  logic [OUT_COUNT_BITS-1:0] cluster_count;

  modport source (input clk, output valid, output boundary_before, output cluster_count,
                  input ready);
  modport sink (input clk, input valid, input boundary_before, input cluster_count,
                output ready);
endinterface

### hw/rtl/grapheme_boundary_marker.sv
// Grapheme boundary marker: takes one decoded code point per item on points and returns one
// item on marks with boundary_before and the running cluster count of the current string
// (saturating). An item flagged is_last closes the string. An item is taken into an input
// register, classified against the fixed range table and the cluster mode, and lands in
// the result register: one item per cycle sustained while marks is ready. The single
// cluster-mode register, updated once per item, sets that rate. Stalls on marks propagate
// back to points without losing or repeating items.
module grapheme_boundary_marker import gbm_pkg::*; (
  input logic      clk,
  input logic      rst,
  gbm_in_if.sink   points,
  gbm_out_if.source marks
);

  logic                      s1_valid;
  logic [CP_BITS-1:0]        s1_codepoint;
  logic                      s1_is_last;
  logic                      out_valid;
  logic                      out_boundary;
  logic [OUT_COUNT_BITS-1:0] out_count;

  cluster_mode_t             mode;
  cluster_mode_t             mode_next;
  logic [COUNT_BITS-1:0]     count;
  logic [COUNT_BITS-1:0]     count_next;

  cp_class_t                 cls;
  cluster_mode_t             base_mode;
  logic                      boundary;
  logic                      restart;
  logic                      advance;
  logic [COUNT_BITS-1:0]     count_base;

  gbm_classify u_classify (
    .codepoint (s1_codepoint),
    .cls       (cls)
  );

  assign advance      = s1_valid && (!out_valid || marks.ready);
  assign points.ready = !s1_valid || advance;

  assign marks.valid           = out_valid;
  assign marks.boundary_before = out_boundary;
  assign marks.cluster_count   = out_count;

  always_comb begin
    if (cls.is_cr) begin
      base_mode = MODE_AFTER_CR;
    end else if (cls.regional) begin
      base_mode = MODE_AFTER_RI;
    end else begin
      base_mode = MODE_EXTENDING;
    end
  end

  // next mode
  always_comb begin
    unique case (mode)
      MODE_AFTER_CR: begin
        mode_next = cls.is_lf ? MODE_CLOSED : base_mode;
      end
      MODE_AFTER_RI: begin
        mode_next = cls.regional ? MODE_CLOSED : base_mode;
      end
      MODE_EXTENDING: begin
        if (cls.attach) begin
          mode_next = MODE_EXTENDING;
        end else if (cls.is_zwj && !s1_is_last) begin
          mode_next = MODE_JOINED;
        end else begin
          mode_next = base_mode;
        end
      end
      MODE_JOINED: begin
        mode_next = MODE_EXTENDING;
      end
      default: begin
        mode_next = base_mode;
      end
    endcase
  end

  // boundary decision
  always_comb begin
    restart = 1'b0;
    unique case (mode)
      MODE_AFTER_CR:  boundary = !cls.is_lf;
      MODE_AFTER_RI:  boundary = !cls.regional;
      MODE_EXTENDING: boundary = !cls.attach && !(cls.is_zwj && !s1_is_last);
      MODE_JOINED:    boundary = 1'b0;
      MODE_CLOSED:    boundary = 1'b1;
      default: begin
        boundary = 1'b1;
        restart  = 1'b1;
      end
    endcase
  end

  always_comb begin
    count_base = restart ? '0 : count;
    if (boundary && (count_base != '1)) begin
      count_next = count_base + 1'b1;
    end else begin
      count_next = count_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MODE_START;
      count     <= '0;
    end else begin
      if (points.ready) begin
        s1_valid <= points.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        mode      <= s1_is_last ? MODE_START : mode_next;
        count     <= count_next;
      end else if (marks.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      s1_codepoint <= points.codepoint;
      s1_is_last   <= points.is_last;
    end
    if (advance) begin
      out_boundary <= boundary;
      out_count    <= sat_count(count_next);
    end
  end

endmodule

### hw/rtl/gbm_classify.sv
module gbm_classify import gbm_pkg::*; (
  input  logic [CP_BITS-1:0] codepoint,
  output cp_class_t          cls
);

  logic attach;

  // all range compares side by side
  always_comb begin
    attach = 1'b0;
    for (int k = 0; k < SPAN_COUNT; k++) begin
      if (codepoint >= ATTACH_SPANS[k].lo && codepoint <= ATTACH_SPANS[k].hi) begin
        attach = 1'b1;
      end
    end
  end

  always_comb begin
    cls.is_cr    = (codepoint == CP_CR);
    cls.is_lf    = (codepoint == CP_LF);
    cls.is_zwj   = (codepoint == CP_ZWJ);
    cls.regional = (codepoint >= RI_FIRST) && (codepoint <= RI_LAST);
    cls.attach   = attach;
  end

endmodule

### hw/rtl/gbm_checker.sv
module gbm_checker import gbm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_boundary,
  input logic [OUT_COUNT_BITS-1:0] out_count
);

  logic                      prev_ok;
  logic [OUT_COUNT_BITS-1:0] prev_count;

  // last count handed out on the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ok <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_count <= out_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_boundary))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count != '0)
    else $error("cluster count of zero reported");

  a_same_cluster: assert property (@(posedge clk) disable iff (rst)
    out_valid && prev_ok && !out_boundary |-> out_count == prev_count)
    else $error("count moved without a boundary");

  a_new_cluster: assert property (@(posedge clk) disable iff (rst)
    out_valid && prev_ok && out_boundary |->
      (out_count == prev_count + 1'b1) || (out_count == OUT_COUNT_BITS'(1)) ||
      (out_count == '1))
    else $error("count step at a boundary is wrong");

endmodule

bind grapheme_boundary_marker gbm_checker u_gbm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (marks.valid),
  .out_ready    (marks.ready),
  .out_boundary (marks.boundary_before),
  .out_count    (marks.cluster_count)
);
